@@ design/mksq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksq_pkg
// Shared sizes, codes and types of the min-key slot scheduler queue.
// ----------------------------------------------------------------------------
package mksq_pkg;

    localparam int SLOTS       = 64;
    localparam int HANDLE_BITS = 16;
    localparam int KEY_BITS    = 32;

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NODE_W    = SLOT_W + 1;
    localparam int NODES     = 2 ** NODE_W;
    localparam int PAY_BITS  = HANDLE_BITS + KEY_BITS;
    localparam int DATA_W    = ((PAY_BITS + 7) / 8) * 8;
    localparam int STATUS_W  = 2;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                occ;
        logic [KEY_BITS-1:0] key;
        logic [SLOT_W-1:0]   slot;
    } t_node;

    localparam int NODE_BITS = $bits(t_node);

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_RD_ROOT,
        DP_RD_TAIL,
        DP_RD_HTAIL,
        DP_MOVE,
        DP_LEAF_INS,
        DP_LEAF_CLR,
        DP_RD_SIB,
        DP_UP,
        DP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic [STATUS_W-1:0] res_status;
        logic                res_data;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic full;
        logic empty;
        logic root_occ;
        logic at_root;
    } t_dp_stat;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] n;
        n = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
        return n;
    endfunction

endpackage

@@ design/mksq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksq_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mksq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/mksq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksq_datapath
// Ring pointers, handle store, tournament-tree store and result registers.
// ----------------------------------------------------------------------------
module mksq_datapath
    import mksq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [HANDLE_BITS-1:0] i_handle,
    input  logic [KEY_BITS-1:0]    i_key,
    output t_dp_stat               o_stat,
    output logic [STATUS_W-1:0]    o_status,
    output logic [HANDLE_BITS-1:0] o_handle,
    output logic [KEY_BITS-1:0]    o_key
);

    logic [SLOT_W-1:0]      r_head, r_tail, r_idx;
    logic [NODE_W-1:0]      r_clr, r_node;
    t_node                  r_cur;
    logic [KEY_BITS-1:0]    r_tail_key, r_ex_key;
    logic [HANDLE_BITS-1:0] r_ex_handle;
    logic [STATUS_W-1:0]    r_status;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [KEY_BITS-1:0]    r_key;

    logic                   n_we;
    logic [NODE_W-1:0]      n_waddr, n_raddr;
    t_node                  n_wnode, w_rnode, w_left, w_right, w_parent;
    logic [NODE_BITS-1:0]   w_rdata;
    logic                   n_hwe;
    logic [SLOT_W-1:0]      n_hwaddr, n_hraddr;
    logic [HANDLE_BITS-1:0] n_hwdata, w_hrdata;

    assign w_rnode = t_node'(w_rdata);

    // parent of the current node and its sibling; right child wins ties
    always_comb begin
        w_left   = r_node[0] ? w_rnode : r_cur;
        w_right  = r_node[0] ? r_cur : w_rnode;
        w_parent = w_right;
        if (w_left.occ && w_right.occ) begin
            w_parent = (w_left.key < w_right.key) ? w_left : w_right;
        end else if (w_left.occ) begin
            w_parent = w_left;
        end else if (!w_right.occ) begin
            w_parent.key = '1;
        end
    end

    always_comb begin
        n_we     = 1'b0;
        n_waddr  = '0;
        n_wnode  = '0;
        n_raddr  = '0;
        n_hwe    = 1'b0;
        n_hwaddr = r_head;
        n_hwdata = i_handle;
        n_hraddr = r_tail;
        case (i_cmd.op)
            DP_CLEAR: begin
                n_we         = 1'b1;
                n_waddr      = r_clr;
                n_wnode.occ  = 1'b0;
                n_wnode.key  = '1;
                n_wnode.slot = r_clr[NODE_W-1] ? r_clr[SLOT_W-1:0] : '0;
            end
            DP_RD_ROOT: begin
                n_raddr = NODE_W'(1);
            end
            DP_RD_TAIL: begin
                n_raddr  = {1'b1, r_tail};
                n_hraddr = w_rnode.slot;
            end
            DP_MOVE: begin
                n_hwe    = 1'b1;
                n_hwaddr = r_idx;
                n_hwdata = w_hrdata;
                n_we     = 1'b1;
                n_waddr  = {1'b1, r_idx};
                n_wnode  = '{occ: 1'b1, key: r_tail_key, slot: r_idx};
            end
            DP_LEAF_INS: begin
                n_hwe   = 1'b1;
                n_we    = 1'b1;
                n_waddr = {1'b1, r_head};
                n_wnode = '{occ: 1'b1, key: i_key, slot: r_head};
            end
            DP_LEAF_CLR: begin
                n_we    = 1'b1;
                n_waddr = {1'b1, r_tail};
                n_wnode = '{occ: 1'b0, key: '1, slot: r_tail};
            end
            DP_RD_SIB: begin
                n_raddr = r_node ^ NODE_W'(1);
            end
            DP_UP: begin
                n_we    = 1'b1;
                n_waddr = r_node >> 1;
                n_wnode = w_parent;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_clr    <= '0;
            r_status <= ST_DONE;
        end else begin
            case (i_cmd.op)
                DP_CLEAR:    r_clr  <= r_clr + 1'b1;
                DP_LEAF_INS: r_head <= next_slot(r_head);
                DP_LEAF_CLR: r_tail <= next_slot(r_tail);
                DP_RESULT:   r_status <= i_cmd.res_status;
                default: begin
                end
            endcase
        end
        case (i_cmd.op)
            DP_RD_TAIL: begin
                r_idx    <= w_rnode.slot;
                r_ex_key <= w_rnode.key;
            end
            DP_RD_HTAIL: begin
                r_tail_key  <= w_rnode.key;
                r_ex_handle <= w_hrdata;
            end
            DP_MOVE, DP_LEAF_INS, DP_LEAF_CLR: begin
                r_node <= n_waddr;
                r_cur  <= n_wnode;
            end
            DP_UP: begin
                r_node <= r_node >> 1;
                r_cur  <= w_parent;
            end
            DP_RESULT: begin
                r_handle <= i_cmd.res_data ? r_ex_handle : '0;
                r_key    <= i_cmd.res_data ? r_ex_key : '0;
            end
            default: begin
            end
        endcase
    end

    mksq_ram #(.WIDTH(NODE_BITS), .DEPTH(NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (NODE_BITS'(n_wnode)),
        .i_raddr (n_raddr),
        .o_rdata (w_rdata)
    );

    mksq_ram #(.WIDTH(HANDLE_BITS), .DEPTH(2 ** SLOT_W)) u_handle_ram (
        .i_clk   (i_clk),
        .i_we    (n_hwe),
        .i_waddr (n_hwaddr),
        .i_wdata (n_hwdata),
        .i_raddr (n_hraddr),
        .o_rdata (w_hrdata)
    );

    assign o_stat.clr_last = (r_clr == NODE_W'(NODES - 1));
    assign o_stat.full     = (next_slot(r_head) == r_tail);
    assign o_stat.empty    = (r_head == r_tail);
    assign o_stat.root_occ = w_rnode.occ;
    assign o_stat.at_root  = (r_node == NODE_W'(1));
    assign o_status        = r_status;
    assign o_handle        = r_handle;
    assign o_key           = r_key;

endmodule

@@ design/mksq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksq_ctrl
// Sequencer: clearing pass, command decode, tree walks and result handoff.
// ----------------------------------------------------------------------------
module mksq_ctrl
    import mksq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  logic     i_command,
    input  t_dp_stat i_stat,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    output logic     o_in_ready,
    output logic     o_out_valid
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EX_ROOT, S_EX_HTAIL, S_EX_MOVE,
        S_WALK_RD, S_WALK_UP, S_CLR_LEAF, S_FIN
    } t_state;

    typedef enum logic [1:0] {
        PH_INSERT, PH_MOVE, PH_VACATE
    } t_phase;

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [STATUS_W-1:0] r_res, n_res;
    logic                r_res_data, n_res_data;
    logic                r_out_valid;
    logic                w_load;

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_res      = r_res;
        n_res_data = r_res_data;
        w_load     = 1'b0;
        o_cmd      = '{op: DP_NOP, res_status: r_res, res_data: r_res_data};
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = DP_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_accept) begin
                    n_res_data = 1'b0;
                    if (i_command == CMD_INSERT) begin
                        if (i_stat.full) begin
                            n_res   = ST_FULL;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.op = DP_LEAF_INS;
                            n_phase  = PH_INSERT;
                            n_state  = S_WALK_RD;
                        end
                    end else if (i_stat.empty) begin
                        n_res   = ST_EMPTY;
                        n_state = S_FIN;
                    end else begin
                        o_cmd.op = DP_RD_ROOT;
                        n_state  = S_EX_ROOT;
                    end
                end
            end
            S_EX_ROOT: begin
                o_cmd.op = DP_RD_TAIL;
                if (i_stat.root_occ) begin
                    n_state = S_EX_HTAIL;
                end else begin
                    n_res   = ST_EMPTY;
                    n_state = S_FIN;
                end
            end
            S_EX_HTAIL: begin
                o_cmd.op = DP_RD_HTAIL;
                n_state  = S_EX_MOVE;
            end
            S_EX_MOVE: begin
                o_cmd.op = DP_MOVE;
                n_phase  = PH_MOVE;
                n_state  = S_WALK_RD;
            end
            S_WALK_RD: begin
                if (!i_stat.at_root) begin
                    o_cmd.op = DP_RD_SIB;
                    n_state  = S_WALK_UP;
                end else if (r_phase == PH_MOVE) begin
                    n_state = S_CLR_LEAF;
                end else begin
                    n_res      = ST_DONE;
                    n_res_data = (r_phase == PH_VACATE);
                    n_state    = S_FIN;
                end
            end
            S_WALK_UP: begin
                o_cmd.op = DP_UP;
                n_state  = S_WALK_RD;
            end
            S_CLR_LEAF: begin
                o_cmd.op = DP_LEAF_CLR;
                n_phase  = PH_VACATE;
                n_state  = S_WALK_RD;
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = DP_RESULT;
                    w_load   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_INSERT;
            r_res       <= ST_DONE;
            r_res_data  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_res       <= n_res;
            r_res_data  <= n_res_data;
            r_out_valid <= w_load || (r_out_valid && !i_out_ready);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ design/min_key_slot_scheduler_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_key_slot_scheduler_queue
// Priority queue of task handles keyed by run time, min tournament tree.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one command per item: tuser = command (insert or
//   extract), tdata = task handle and run time. Master channel returns
//   exactly one result per command: tuser = status (done, full, empty),
//   tdata = handle and run time of the extracted task, zero otherwise.
//   Tasks sit in a ring of SLOTS slots (SLOTS-1 usable); a tree of
//   2*SLOTS nodes in block RAM keeps the least key, right child on ties.
//   Tree walk: each tree level is a sibling read and then a parent write
//   on the single read port of the node RAM. One item is in work at a time.
//   Reset: a clearing pass writes every tree node with tready low; the
//   queue then starts empty.
//   Stall: a finished result waits in the output register; the next item
//   is still taken and worked on, and only its handoff waits for tready.
// ----------------------------------------------------------------------------
module min_key_slot_scheduler_queue
    import mksq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [DATA_W-1:0]   i_s_tdata,   // task_handle, run_time
    input  logic                i_s_tuser,   // command
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [DATA_W-1:0]   o_m_tdata,   // out_handle, out_run_time
    output logic [STATUS_W-1:0] o_m_tuser    // status
);

    t_dp_cmd                w_cmd;
    t_dp_stat               w_stat;
    logic                   w_accept;
    logic [HANDLE_BITS-1:0] w_handle;
    logic [KEY_BITS-1:0]    w_key;

    assign w_accept = i_s_tvalid && o_s_tready;

    // sequencer: owns the handshakes and steps the datapath
    mksq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_command   (i_s_tuser),
        .i_stat      (w_stat),
        .i_out_ready (i_m_tready),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid)
    );

    // pointers, stores and result registers
    mksq_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_handle (i_s_tdata[HANDLE_BITS-1:0]),
        .i_key    (i_s_tdata[PAY_BITS-1:HANDLE_BITS]),
        .o_stat   (w_stat),
        .o_status (o_m_tuser),
        .o_handle (w_handle),
        .o_key    (w_key)
    );

    // pack result, zero-fill to whole bytes
    assign o_m_tdata = DATA_W'({w_key, w_handle});

endmodule

@@ design/mksq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksq_checker
// Port-level checks of the scheduler queue, bound to the top level.
// ----------------------------------------------------------------------------
module mksq_checker
    import mksq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic [DATA_W-1:0]   o_m_tdata,
    input logic [STATUS_W-1:0] o_m_tuser,
    input logic                o_m_tvalid,
    input logic                i_m_tready
);

    // only one item in work: ready drops right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("item taken while another is in work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == ST_DONE || o_m_tuser == ST_FULL ||
                        o_m_tuser == ST_EMPTY))
        else $error("undefined status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_DONE) |-> (o_m_tdata == '0))
        else $error("nonzero data on full or empty result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind min_key_slot_scheduler_queue mksq_checker u_mksq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

@@ sim/min_key_slot_scheduler_queue_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_key_slot_scheduler_queue_test
// Drives insert and extract commands into the scheduler queue and checks each
// returned status, handle and run time against a behavioral priority queue.
// ----------------------------------------------------------------------------
module min_key_slot_scheduler_queue_test;
    import mksq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [HANDLE_BITS-1:0] handle;
        logic [KEY_BITS-1:0]    run_time;
    } t_outcome;

    typedef struct {
        logic                   cmd;
        logic [HANDLE_BITS-1:0] handle;
        logic [KEY_BITS-1:0]    run_time;
        bit                     typed;   // expected outcome given in the row
        t_outcome               outcome;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [DATA_W-1:0]   i_s_tdata = '0;   // task_handle, run_time
    logic                i_s_tuser = 1'b0; // command
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [DATA_W-1:0]   o_m_tdata;        // out_handle, out_run_time
    logic [STATUS_W-1:0] o_m_tuser;        // status

    min_key_slot_scheduler_queue dut (.*);

    always #2 i_clk = ~i_clk;

    // Shadow queue: the ring of slots and the key held in each slot.
    logic [SLOT_W-1:0]      head_q, tail_q;
    logic [HANDLE_BITS-1:0] handle_q [SLOTS];
    logic [KEY_BITS-1:0]    key_q [SLOTS];
    t_outcome               pending_q [$];
    int                     mismatches = 0;
    bit                     stim_done = 1'b0;

    function automatic t_outcome apply_command(input logic cmd,
                                               input logic [HANDLE_BITS-1:0] h,
                                               input logic [KEY_BITS-1:0] k);
        t_outcome o;
        int best, s;
        o = '0;
        if (cmd == CMD_INSERT) begin
            if (next_slot(head_q) == tail_q) begin
                o.status = ST_FULL;
            end else begin
                handle_q[head_q] = h;
                key_q[head_q] = k;
                head_q = next_slot(head_q);
                o.status = ST_DONE;
            end
            return o;
        end
        if (head_q == tail_q) begin
            o.status = ST_EMPTY;
            return o;
        end
        // Least key wins; on ties the highest slot index wins.
        best = -1;
        s = int'(tail_q);
        while (s != int'(head_q)) begin
            if (best < 0 || key_q[s] < key_q[best] ||
                (key_q[s] == key_q[best] && s > best))
                best = s;
            s = int'(next_slot(SLOT_W'(s)));
        end
        o.status = ST_DONE;
        o.handle = handle_q[best];
        o.run_time = key_q[best];
        // Fill the hole with the tail entry and retire the tail.
        handle_q[best] = handle_q[tail_q];
        key_q[best] = key_q[tail_q];
        tail_q = next_slot(tail_q);
        return o;
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        mismatches++;
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // Check every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_q.size() == 0) begin
                report("unexpected result, status", 64'(o_m_tuser), '0);
            end else begin
                w = pending_q.pop_front();
                if (o_m_tuser !== w.status)
                    report("status", 64'(o_m_tuser), 64'(w.status));
                if (o_m_tdata[HANDLE_BITS-1:0] !== w.handle)
                    report("handle", 64'(o_m_tdata[HANDLE_BITS-1:0]), 64'(w.handle));
                if (o_m_tdata[PAY_BITS-1:HANDLE_BITS] !== w.run_time)
                    report("run time", 64'(o_m_tdata[PAY_BITS-1:HANDLE_BITS]),
                           64'(w.run_time));
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: stall at random, with stretches of steady acceptance.
    initial begin
        int n;
        while (1) begin
            @(posedge i_clk);
            if ($urandom_range(0, 4) == 0) begin
                n = gap_len();
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(posedge i_clk);
        end
    end

    // Present one item and hold until the handshake completes.
    task automatic send_item(input logic cmd, input logic [HANDLE_BITS-1:0] h,
                             input logic [KEY_BITS-1:0] k, input bit typed,
                             input t_outcome typed_out);
        t_outcome o;
        int n;
        n = gap_len();
        if ($urandom_range(0, 3) != 0) n = 0;
        if (n > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= DATA_W'({k, h});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        o = apply_command(cmd, h, k);
        if (typed && o !== typed_out)
            report("predictor disagrees with table row", 64'(o), 64'(typed_out));
        pending_q.push_back(typed ? typed_out : o);
    endtask

    t_row rows [$];

    task automatic add_row(input logic cmd, input logic [HANDLE_BITS-1:0] h,
                           input logic [KEY_BITS-1:0] k, input bit typed,
                           input logic [STATUS_W-1:0] st,
                           input logic [HANDLE_BITS-1:0] oh,
                           input logic [KEY_BITS-1:0] ok);
        t_row r;
        r.cmd = cmd; r.handle = h; r.run_time = k; r.typed = typed;
        r.outcome = '{st, oh, ok};
        rows.push_back(r);
    endtask

    initial begin
        int cmd, live, i, cnt;
        logic [KEY_BITS-1:0] k;
        head_q = '0;
        tail_q = '0;
        foreach (handle_q[j]) begin
            handle_q[j] = '0;
            key_q[j] = '0;
        end
        // Directed table: empty extract, extremes, equal keys, all-ones key.
        add_row(CMD_EXTRACT, 16'h0000, 32'h0, 1'b1, ST_EMPTY, '0, '0);
        add_row(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_DONE, '0, '0);
        add_row(CMD_EXTRACT, 16'h1234, 32'h0, 1'b1, ST_DONE, 16'hFFFF, 32'hFFFF_FFFF);
        add_row(CMD_EXTRACT, 16'h0, 32'h0, 1'b1, ST_EMPTY, '0, '0);
        add_row(CMD_INSERT, 16'h0000, 32'h0000_0000, 1'b1, ST_DONE, '0, '0);
        add_row(CMD_INSERT, 16'hAAAA, 32'h5555_5555, 1'b1, ST_DONE, '0, '0);
        add_row(CMD_INSERT, 16'h5555, 32'hAAAA_AAAA, 1'b1, ST_DONE, '0, '0);
        add_row(CMD_INSERT, 16'h0101, 32'h5555_5555, 1'b1, ST_DONE, '0, '0);
        add_row(CMD_EXTRACT, 16'h0, 32'h0, 1'b1, ST_DONE, 16'h0000, 32'h0);
        add_row(CMD_EXTRACT, 16'h0, 32'h0, 1'b0, ST_DONE, '0, '0);
        add_row(CMD_EXTRACT, 16'h0, 32'h0, 1'b0, ST_DONE, '0, '0);
        add_row(CMD_EXTRACT, 16'h0, 32'h0, 1'b0, ST_DONE, '0, '0);
        add_row(CMD_EXTRACT, 16'h0, 32'h0, 1'b1, ST_EMPTY, '0, '0);

        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[j])
            send_item(rows[j].cmd, rows[j].handle, rows[j].run_time,
                      rows[j].typed, rows[j].outcome);

        // Fill to capacity so the full answer appears, then drain.
        for (i = 0; i < SLOTS + 1; i++)
            send_item(CMD_INSERT, 16'($urandom), 32'($urandom_range(0, 7)), 1'b0, '0);
        for (i = 0; i < SLOTS + 1; i++)
            send_item(CMD_EXTRACT, 16'($urandom), 32'($urandom), 1'b0, '0);

        // Let every result come home before going on.
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);

        // Random part: bursts biased to insert or extract so the queue swings
        // between empty and full; keys sometimes narrow to force ties.
        cnt = 0;
        while (cnt < 560) begin
            live = $urandom_range(0, 2);
            repeat ($urandom_range(5, 40)) begin
                cmd = (live == 0) ? ($urandom_range(0, 9) < 8 ? 0 : 1) :
                      (live == 1) ? ($urandom_range(0, 9) < 2 ? 0 : 1) :
                                    $urandom_range(0, 1);
                k = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 5)) : 32'($urandom);
                send_item(cmd[0], 16'($urandom), k, 1'b0, '0);
                cnt++;
            end
        end
        i_s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Wrap up once everything expected has arrived.
    initial begin
        wait (stim_done);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
